// ===== hdl/orbraan_pkg.sv =====
// ============================================================================
// orbraan_pkg: shared types and constants for the RAAN pipeline
// Widths of the coordinate, CORDIC and degree-conversion datapaths, the
// CORDIC arctangent table in radians (signed Q.36) and the side-band
// struct that travels with each transaction.
// ============================================================================
package orbraan_pkg;

  // Input fields and the bits of each that are used as a signed coordinate.
  localparam int FIELD_W         = 32;
  localparam int COORD_WIDTH     = 32;
  localparam int PROD_W          = 2 * COORD_WIDTH;

  // Angular momentum magnitudes and their exact differences.
  localparam int MAG_W           = 64;
  localparam int DIFF_W          = MAG_W + 1;

  // Normalization places the leading one of max(|n_x|, |n_y|) at bit 60.
  localparam int NORM_MSB        = 60;
  localparam int NORM_RSH        = MAG_W - 1 - NORM_MSB;
  localparam int NORM_STEPS      = $clog2(MAG_W);
  localparam int NORM_COARSE     = NORM_STEPS / 2;

  // CORDIC angle accumulator and the quadrant-corrected angle.
  localparam int CORDIC_STEPS    = 40;
  localparam int ZW              = 40;
  localparam int A_W             = 39;

  localparam logic [A_W-1:0] PI_Q36      = A_W'(64'd215888603272);
  localparam logic [A_W-1:0] HALF_PI_Q36 = A_W'(64'd107944301636);

  // Conversion to degrees: 180/pi in unsigned Q.24, applied to the angle
  // split into a high part and a 16-bit low part.
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int ANGLE_OUT_BITS  = ANGLE_FRAC_BITS + 9;
  localparam int LO_W            = 16;
  localparam int HI_W            = A_W - LO_W;
  localparam int K_W             = 30;
  localparam logic [K_W-1:0] DEG_PER_RAD = K_W'(961263669);
  localparam int HI_PROD_W       = HI_W + K_W;
  localparam int LO_PROD_W       = LO_W + K_W;
  localparam int ACC_W           = HI_PROD_W + 1;
  localparam int DEG_SHIFT       = 60 - ANGLE_FRAC_BITS - LO_W;
  localparam int DEG_W           = ACC_W - DEG_SHIFT;
  localparam logic [DEG_W-1:0] FULL_TURN = DEG_W'(360) << ANGLE_FRAC_BITS;

  // Quadrant and degenerate-case flags carried alongside the datapath.
  typedef struct packed {
    logic nx_neg;
    logic ny_neg;
    logic undef;
  } node_side_t;

  // atan(2^-i) in radians, signed Q.36, rounded to nearest.
  function automatic logic signed [ZW-1:0] cordic_atan(input int unsigned idx);
    logic signed [ZW-1:0] t;
    case (idx)
      0:       t = ZW'(64'd53972150818);
      1:       t = ZW'(64'd31861621080);
      2:       t = ZW'(64'd16834805542);
      3:       t = ZW'(64'd8545610155);
      4:       t = ZW'(64'd4289387961);
      5:       t = ZW'(64'd2146785007);
      6:       t = ZW'(64'd1073654455);
      7:       t = ZW'(64'd536859990);
      8:       t = ZW'(64'd268434091);
      9:       t = ZW'(64'd134217557);
      10:      t = ZW'(64'd67108843);
      11:      t = ZW'(64'd33554429);
      12:      t = ZW'(64'd16777216);
      37:      t = ZW'(1);
      default: t = (idx inside {[13:36]}) ? (ZW'(1) << (36 - idx)) : '0;
    endcase
    return t;
  endfunction

endpackage

// ===== hdl/orbraan_if.sv =====
// ============================================================================
// orbraan_if: valid/ready channels of the RAAN pipeline
// The state-vector input channel and the node-angle result channel.
// ============================================================================
interface orbraan_in_if import orbraan_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] pos_x;
  logic signed [FIELD_W-1:0] pos_y;
  logic signed [FIELD_W-1:0] pos_z;
  logic signed [FIELD_W-1:0] vel_x;
  logic signed [FIELD_W-1:0] vel_y;
  logic signed [FIELD_W-1:0] vel_z;

  modport source (
    output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
    output ready
  );
endinterface

interface orbraan_out_if import orbraan_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [ANGLE_OUT_BITS-1:0] node_angle;
  logic                      undefined;

  modport source (
    output valid, node_angle, undefined,
    input  ready
  );
  modport sink (
    input  valid, node_angle, undefined,
    output ready
  );
endinterface

// ===== hdl/orbraan_cordic.sv =====
// ============================================================================
// orbraan_cordic: pipelined vectoring CORDIC
// One micro-rotation per register stage. Drives y toward zero and
// accumulates the rotation angle in signed Q.36 radians.
// ============================================================================
module orbraan_cordic import orbraan_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [MAG_W-1:0] in_x,
  input  logic signed [MAG_W-1:0] in_y,
  input  node_side_t              in_side,
  output logic                    out_valid,
  output logic signed [ZW-1:0]    out_z,
  output node_side_t              out_side
);

  logic                    v_r [CORDIC_STEPS];
  logic signed [MAG_W-1:0] x_r [CORDIC_STEPS];
  logic signed [MAG_W-1:0] y_r [CORDIC_STEPS];
  logic signed [ZW-1:0]    z_r [CORDIC_STEPS];
  node_side_t              s_r [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [ZW-1:0] ANG = cordic_atan(i);

    logic                    v_in;
    logic signed [MAG_W-1:0] x_in;
    logic signed [MAG_W-1:0] y_in;
    logic signed [ZW-1:0]    z_in;
    node_side_t              s_in;
    logic signed [MAG_W-1:0] xs;
    logic signed [MAG_W-1:0] ys;
    logic signed [MAG_W-1:0] x_nxt;
    logic signed [MAG_W-1:0] y_nxt;
    logic signed [ZW-1:0]    z_nxt;

    if (i == 0) begin : g_first
      assign v_in = in_valid;
      assign x_in = in_x;
      assign y_in = in_y;
      assign z_in = '0;
      assign s_in = in_side;
    end else begin : g_next
      assign v_in = v_r[i-1];
      assign x_in = x_r[i-1];
      assign y_in = y_r[i-1];
      assign z_in = z_r[i-1];
      assign s_in = s_r[i-1];
    end

    always_comb begin
      xs    = x_in >>> i;
      ys    = y_in >>> i;
      x_nxt = x_in;
      y_nxt = y_in;
      z_nxt = z_in;
      if (!y_in[MAG_W-1] && (y_in != '0)) begin
        x_nxt = x_in + ys;
        y_nxt = y_in - xs;
        z_nxt = z_in + ANG;
      end else if (y_in[MAG_W-1]) begin
        x_nxt = x_in - ys;
        y_nxt = y_in + xs;
        z_nxt = z_in - ANG;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i] <= x_nxt;
        y_r[i] <= y_nxt;
        z_r[i] <= z_nxt;
        s_r[i] <= s_in;
      end
    end
  end

  assign out_valid = v_r[CORDIC_STEPS-1];
  assign out_z     = z_r[CORDIC_STEPS-1];
  assign out_side  = s_r[CORDIC_STEPS-1];

endmodule

// ===== hdl/orbit_raan_from_state_vector.sv =====
// ============================================================================
// orbit_raan_from_state_vector: right ascension of the ascending node
// Cross product, exact node vector, normalization, 40-step vectoring
// CORDIC and conversion to degrees, fully pipelined.
// ============================================================================
// The block takes one state vector per transaction and returns one result
// per transaction, in order, at a sustained rate of one per clock cycle
// while the output side does not stall. Each result passes 49 registers:
// five front-end stages (multiply, subtract, magnitude, two normalization
// stages), one stage per CORDIC micro-rotation (40), three back-end stages
// (quadrant fold, degree multiply, round) and the output register.
// While a result waits at the output, the whole pipeline holds, but the
// input stage still takes one more transaction if it is empty. The angle
// is in degrees in [0, 360) with 16 fraction bits; when the node vector is
// zero (an equatorial orbit) undefined is 1 and node_angle is 0.
module orbit_raan_from_state_vector import orbraan_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  orbraan_in_if.sink    in_ch,
  orbraan_out_if.source out_ch
);

  // Pipeline advance: everything moves when the output register is free
  // or being emptied this cycle.
  logic en;
  logic in_take;

  // Stage 1: the four coordinate products.
  logic                          s1_v_r;
  logic signed [PROD_W-1:0]      s1_pa_r;  // ry * vz
  logic signed [PROD_W-1:0]      s1_pb_r;  // rz * vy
  logic signed [PROD_W-1:0]      s1_pc_r;  // rz * vx
  logic signed [PROD_W-1:0]      s1_pd_r;  // rx * vz
  logic signed [COORD_WIDTH-1:0] rx, ry, rz, vx, vy, vz;

  // Stage 2: exact momentum components h_x and h_y.
  logic                     s2_v_r;
  logic signed [DIFF_W-1:0] s2_hx_r;
  logic signed [DIFF_W-1:0] s2_hy_r;

  // Stage 3: magnitudes of the node vector and its quadrant flags.
  logic                     s3_v_r;
  logic [MAG_W-1:0]         s3_ax_r;
  logic [MAG_W-1:0]         s3_ay_r;
  node_side_t               s3_side_r;
  logic signed [DIFF_W-1:0] hx_abs;
  logic signed [DIFF_W-1:0] hy_abs;
  node_side_t               s3_side_nxt;

  // Stages 4 and 5: normalization of the magnitudes.
  logic             s4_v_r;
  logic [MAG_W-1:0] s4_w_r;
  logic [MAG_W-1:0] s4_ax_r;
  logic [MAG_W-1:0] s4_ay_r;
  node_side_t       s4_side_r;
  logic [MAG_W-1:0] s4_w_nxt, s4_ax_nxt, s4_ay_nxt;

  logic                    s5_v_r;
  logic signed [MAG_W-1:0] s5_x_r;
  logic signed [MAG_W-1:0] s5_y_r;
  node_side_t              s5_side_r;
  logic [MAG_W-1:0]        s5_w, s5_ax, s5_ay;

  // CORDIC outputs.
  logic                 c_v;
  logic signed [ZW-1:0] c_z;
  node_side_t           c_side;

  // Stage 6: clamped angle folded into the full circle.
  logic           s6_v_r;
  logic [A_W-1:0] s6_ang_r;
  node_side_t     s6_side_r;
  logic [A_W-1:0] theta;
  logic [A_W-1:0] s6_ang_nxt;

  // Stage 7: partial products of the radian-to-degree scaling.
  logic                 s7_v_r;
  logic [HI_PROD_W-1:0] s7_mhi_r;
  logic [LO_PROD_W-1:0] s7_mlo_r;
  node_side_t           s7_side_r;

  // Stage 8: rounded degrees before the full-turn wrap.
  logic             s8_v_r;
  logic [DEG_W-1:0] s8_deg_r;
  node_side_t       s8_side_r;
  logic [ACC_W-1:0] acc;

  // Output register.
  logic                      out_valid_r;
  logic [ANGLE_OUT_BITS-1:0] node_angle_r;
  logic                      undefined_r;
  logic [DEG_W-1:0]          deg_wrap;
  logic [ANGLE_OUT_BITS-1:0] node_angle_nxt;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_take     = en || !s1_v_r;
  assign in_ch.ready = in_take;

  // --------------------------------------------------------------------------
  // Stage 1. Only the low COORD_WIDTH bits of each field are used, as a
  // two's complement value of that width. The input stage loads on its own
  // when it is empty, so one transaction is taken even during a stall.
  // --------------------------------------------------------------------------
  assign rx = in_ch.pos_x[COORD_WIDTH-1:0];
  assign ry = in_ch.pos_y[COORD_WIDTH-1:0];
  assign rz = in_ch.pos_z[COORD_WIDTH-1:0];
  assign vx = in_ch.vel_x[COORD_WIDTH-1:0];
  assign vy = in_ch.vel_y[COORD_WIDTH-1:0];
  assign vz = in_ch.vel_z[COORD_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_take) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pa_r <= ry * vz;
      s1_pb_r <= rz * vy;
      s1_pc_r <= rz * vx;
      s1_pd_r <= rx * vz;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2. The differences are held one bit wider than the products so
  // that they are exact for every input.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (en) begin
      s2_hx_r <= DIFF_W'(s1_pa_r) - DIFF_W'(s1_pb_r);
      s2_hy_r <= DIFF_W'(s1_pc_r) - DIFF_W'(s1_pd_r);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3. The node vector is (-h_y, h_x). Its x component is negative
  // when h_y is positive, its y component when h_x is negative. The CORDIC
  // works on magnitudes in the first quadrant and the flags fold the angle
  // back later.
  // --------------------------------------------------------------------------
  always_comb begin
    hx_abs = s2_hx_r[DIFF_W-1] ? -s2_hx_r : s2_hx_r;
    hy_abs = s2_hy_r[DIFF_W-1] ? -s2_hy_r : s2_hy_r;
    s3_side_nxt.nx_neg = !s2_hy_r[DIFF_W-1] && (s2_hy_r != '0);
    s3_side_nxt.ny_neg = s2_hx_r[DIFF_W-1];
    s3_side_nxt.undef  = (s2_hx_r == '0) && (s2_hy_r == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_ax_r   <= hy_abs[MAG_W-1:0];
      s3_ay_r   <= hx_abs[MAG_W-1:0];
      s3_side_r <= s3_side_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 4 and 5. Both magnitudes are shifted left until the leading one
  // of their OR (the same bit as the leading one of the larger) reaches the
  // top bit, coarse shifts first, then moved right so that it sits at bit
  // 60. Bits that fall off on the right are dropped, as a plain right shift
  // would when the larger magnitude is already above bit 60.
  // --------------------------------------------------------------------------
  always_comb begin
    s4_w_nxt  = s3_ax_r | s3_ay_r;
    s4_ax_nxt = s3_ax_r;
    s4_ay_nxt = s3_ay_r;
    for (int k = 0; k < NORM_COARSE; k++) begin
      if ((s4_w_nxt >> (MAG_W - ((MAG_W / 2) >> k))) == '0) begin
        s4_w_nxt  = s4_w_nxt << ((MAG_W / 2) >> k);
        s4_ax_nxt = s4_ax_nxt << ((MAG_W / 2) >> k);
        s4_ay_nxt = s4_ay_nxt << ((MAG_W / 2) >> k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_w_r    <= s4_w_nxt;
      s4_ax_r   <= s4_ax_nxt;
      s4_ay_r   <= s4_ay_nxt;
      s4_side_r <= s3_side_r;
    end
  end

  always_comb begin
    s5_w  = s4_w_r;
    s5_ax = s4_ax_r;
    s5_ay = s4_ay_r;
    for (int k = NORM_COARSE; k < NORM_STEPS; k++) begin
      if ((s5_w >> (MAG_W - ((MAG_W / 2) >> k))) == '0) begin
        s5_w  = s5_w << ((MAG_W / 2) >> k);
        s5_ax = s5_ax << ((MAG_W / 2) >> k);
        s5_ay = s5_ay << ((MAG_W / 2) >> k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_x_r    <= s5_ax >> NORM_RSH;
      s5_y_r    <= s5_ay >> NORM_RSH;
      s5_side_r <= s4_side_r;
    end
  end

  // Valid bits of the front end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
    end
  end

  // --------------------------------------------------------------------------
  // Vectoring CORDIC: the accumulated angle is atan(ay / ax) in radians.
  // --------------------------------------------------------------------------
  orbraan_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s5_v_r),
    .in_x      (s5_x_r),
    .in_y      (s5_y_r),
    .in_side   (s5_side_r),
    .out_valid (c_v),
    .out_z     (c_z),
    .out_side  (c_side)
  );

  // --------------------------------------------------------------------------
  // Stage 6. The first-quadrant angle is clamped to [0, pi/2] and then
  // placed in its quadrant by the signs of the node vector.
  // --------------------------------------------------------------------------
  always_comb begin
    if (c_z[ZW-1]) begin
      theta = '0;
    end else if (c_z[ZW-2:0] > (ZW-1)'(HALF_PI_Q36)) begin
      theta = HALF_PI_Q36;
    end else begin
      theta = c_z[A_W-1:0];
    end

    if (!c_side.nx_neg && !c_side.ny_neg) begin
      s6_ang_nxt = theta;
    end else if (c_side.nx_neg && !c_side.ny_neg) begin
      s6_ang_nxt = PI_Q36 - theta;
    end else if (c_side.nx_neg && c_side.ny_neg) begin
      s6_ang_nxt = PI_Q36 + theta;
    end else begin
      s6_ang_nxt = (PI_Q36 << 1) - theta;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_ang_r  <= s6_ang_nxt;
      s6_side_r <= c_side;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7. Radians times 180/pi, split into a high and a low product so
  // that each multiplier stays narrow.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (en) begin
      s7_mhi_r  <= s6_ang_r[A_W-1:LO_W] * DEG_PER_RAD;
      s7_mlo_r  <= s6_ang_r[LO_W-1:0] * DEG_PER_RAD;
      s7_side_r <= s6_side_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8. The low product is truncated before the sum; the sum is then
  // rounded to nearest, half up, to ANGLE_FRAC_BITS fraction bits.
  // --------------------------------------------------------------------------
  assign acc = ACC_W'(s7_mhi_r) + ACC_W'(s7_mlo_r >> LO_W)
             + (ACC_W'(1) << (DEG_SHIFT - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      s8_deg_r  <= acc[ACC_W-1:DEG_SHIFT];
      s8_side_r <= s7_side_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
      s8_v_r <= 1'b0;
    end else if (en) begin
      s6_v_r <= c_v;
      s7_v_r <= s6_v_r;
      s8_v_r <= s7_v_r;
    end
  end

  // --------------------------------------------------------------------------
  // Output register. A rounded full turn wraps to zero, and an equatorial
  // orbit reports zero with the undefined flag set.
  // --------------------------------------------------------------------------
  always_comb begin
    deg_wrap       = (s8_deg_r >= FULL_TURN) ? (s8_deg_r - FULL_TURN) : s8_deg_r;
    node_angle_nxt = s8_side_r.undef ? '0 : deg_wrap[ANGLE_OUT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s8_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      node_angle_r <= node_angle_nxt;
      undefined_r  <= s8_side_r.undef;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.node_angle = node_angle_r;
  assign out_ch.undefined  = undefined_r;

endmodule

// ===== tb/orbit_raan_from_state_vector_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// orbit_raan_from_state_vector_tb: self-checking bench for the RAAN pipeline
// Drives orbital state vectors through the valid/ready input channel and
// checks every result transaction against a bench-side model of the cross
// product, the vectoring CORDIC and the conversion to degrees. The angle is
// accepted within 2 LSB around the full turn. The undefined flag must match
// exactly. A directed table comes first. It is followed by random vectors
// with random idling on both sides and two long output stalls.
// ============================================================================
module orbit_raan_from_state_vector_tb import orbraan_pkg::*; ();

  // Rotation count, the 180/pi factor in Q.24, and the shift that takes the
  // split product down to the output's fraction bits.
  localparam int              N_ROT     = 40;
  localparam longint unsigned DEG_K     = 64'd961263669;
  localparam int              DEG_SH    = 60 - ANGLE_FRAC_BITS - 16;
  localparam int              TURN      = 360 << ANGLE_FRAC_BITS;
  localparam int              ANG_TOL   = 2;

  localparam int              IDLE_PCT  = 29;
  localparam int              N_RANDOM  = 530;
  localparam int              DRAIN     = 64;    // longer than the pipeline is deep
  localparam int              HOLD_LEN  = 250;

  localparam logic signed [FIELD_W-1:0] V_MIN = 32'sh8000_0000;
  localparam logic signed [FIELD_W-1:0] V_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [FIELD_W-1:0] V_ALT = 32'sh5555_5555;
  localparam logic signed [FIELD_W-1:0] V_INV = 32'shAAAA_AAAA;

  localparam logic [ANGLE_OUT_BITS-1:0] ANG_0   = '0;
  localparam logic [ANGLE_OUT_BITS-1:0] ANG_45  = ANGLE_OUT_BITS'(45 << ANGLE_FRAC_BITS);
  localparam logic [ANGLE_OUT_BITS-1:0] ANG_90  = ANGLE_OUT_BITS'(90 << ANGLE_FRAC_BITS);
  localparam logic [ANGLE_OUT_BITS-1:0] ANG_135 = ANGLE_OUT_BITS'(135 << ANGLE_FRAC_BITS);
  localparam logic [ANGLE_OUT_BITS-1:0] ANG_180 = ANGLE_OUT_BITS'(180 << ANGLE_FRAC_BITS);
  localparam logic [ANGLE_OUT_BITS-1:0] ANG_225 = ANGLE_OUT_BITS'(225 << ANGLE_FRAC_BITS);
  localparam logic [ANGLE_OUT_BITS-1:0] ANG_270 = ANGLE_OUT_BITS'(270 << ANGLE_FRAC_BITS);
  localparam logic [ANGLE_OUT_BITS-1:0] ANG_315 = ANGLE_OUT_BITS'(315 << ANGLE_FRAC_BITS);

  typedef struct packed {
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [FIELD_W-1:0] pos_z;
    logic signed [FIELD_W-1:0] vel_x;
    logic signed [FIELD_W-1:0] vel_y;
    logic signed [FIELD_W-1:0] vel_z;
  } state_vec_t;

  typedef struct packed {
    logic [ANGLE_OUT_BITS-1:0] node_angle;
    logic                      undefined;
  } node_result_t;

  // A stimulus row. When has_want is set, the expected result is the one
  // typed into the row; otherwise the model below supplies it.
  typedef struct packed {
    state_vec_t   vec;
    logic         has_want;
    node_result_t want;
  } stim_item_t;

  typedef enum {VAL_FULL, VAL_SMALL, VAL_MID, VAL_EXTREME} val_class_t;

  logic clk;
  logic rst_n;

  orbraan_in_if  in_ch ();
  orbraan_out_if out_ch ();

  orbit_raan_from_state_vector u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // --------------------------------------------------------------------------
  // Model of the block
  // --------------------------------------------------------------------------
  // CORDIC micro-rotation angles and pi, both in radians as signed Q.36.
  longint rot_angle [N_ROT];
  longint pi_q36;

  // Alternating arctangent series in Q.60, starting from the first term.
  // A ratio shift of zero means the terms shrink by 9 (argument 1/3);
  // otherwise they shrink by 2**ratio_sh.
  function automatic longint unsigned atan_series(longint unsigned first,
                                                  int unsigned ratio_sh);
    longint unsigned p, sum, d;
    bit add;
    p   = first;
    sum = 0;
    d   = 1;
    add = 1'b1;
    while (p != 0) begin
      if (add) sum += p / d;
      else     sum -= p / d;
      add = !add;
      if (ratio_sh == 0)       p = p / 9;
      else if (ratio_sh >= 64) p = 0;
      else                     p = p >> ratio_sh;
      d += 2;
    end
    return sum;
  endfunction

  // The first rotation is by pi/4, built as atan(1/3) + atan(1/2) so that
  // every series converges fast.
  function automatic longint unsigned atan_q60(int i);
    if (i == 0)
      return atan_series((64'd1 << 60) / 3, 0) + atan_series(64'd1 << 59, 2);
    return atan_series((i <= 60) ? (64'd1 << (60 - i)) : 64'd0, 2 * i);
  endfunction

  function automatic longint q60_to_q36(longint unsigned v);
    return longint'((v + (64'd1 << 23)) >> 24);
  endfunction

  function automatic node_result_t predict_node_angle(state_vec_t v);
    longint          rx, ry, rz, vx, vy, vz, pa, pb, qa, qb;
    longint unsigned hx_mag, hy_mag, ax, ay, m, hi_u, lo_u, q, acc, deg;
    bit              hx_neg, hy_neg, nx_neg, ny_neg;
    int              top;
    longint          x, y, z, xs, ys, theta, a;
    node_result_t    r;
    rx = longint'($signed(v.pos_x));
    ry = longint'($signed(v.pos_y));
    rz = longint'($signed(v.pos_z));
    vx = longint'($signed(v.vel_x));
    vy = longint'($signed(v.vel_y));
    vz = longint'($signed(v.vel_z));
    r  = '0;

    // Momentum components as exact sign and magnitude; the magnitude can
    // exceed 2**62, so the subtraction is taken as a 64-bit unsigned pattern.
    pa     = ry * vz;
    pb     = rz * vy;
    qa     = rz * vx;
    qb     = rx * vz;
    hx_neg = pa < pb;
    hy_neg = qa < qb;
    hx_mag = hx_neg ? pb - pa : pa - pb;
    hy_mag = hy_neg ? qb - qa : qa - qb;

    // The node vector is (-h_y, h_x).
    nx_neg = !hy_neg && (hy_mag != 0);
    ny_neg = hx_neg && (hx_mag != 0);
    if (hx_mag == 0 && hy_mag == 0) begin
      r.undefined = 1'b1;
      return r;
    end

    // Put the leading one of the larger magnitude at bit 60.
    ax  = hy_mag;
    ay  = hx_mag;
    m   = (ax > ay) ? ax : ay;
    top = 0;
    for (int i = 0; i < 64; i++)
      if (m[i]) top = i;
    if (top > 60) begin
      ax = ax >> (top - 60);
      ay = ay >> (top - 60);
    end else begin
      ax = ax << (60 - top);
      ay = ay << (60 - top);
    end

    // Vectoring: drive y to zero and collect the angle in z.
    x = longint'(ax);
    y = longint'(ay);
    z = 0;
    for (int i = 0; i < N_ROT; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys;
        y -= xs;
        z += rot_angle[i];
      end else if (y < 0) begin
        x -= ys;
        y += xs;
        z -= rot_angle[i];
      end
    end
    theta = z;
    if (theta < 0)          theta = 0;
    if (theta > pi_q36 / 2) theta = pi_q36 / 2;

    // Fold the first-quadrant angle out to the quadrant of the node vector.
    if (!nx_neg && !ny_neg)     a = theta;
    else if (nx_neg && !ny_neg) a = pi_q36 - theta;
    else if (nx_neg && ny_neg)  a = pi_q36 + theta;
    else                        a = 2 * pi_q36 - theta;

    // Degrees: the angle split at bit 16, each half times 180/pi, then
    // rounded half up. A rounded full turn wraps to zero.
    hi_u = longint'(a >>> 16);
    lo_u = a & 64'hFFFF;
    q    = (lo_u * DEG_K) >> 16;
    acc  = hi_u * DEG_K + q;
    acc += 64'd1 << (DEG_SH - 1);
    deg  = acc >> DEG_SH;
    if (deg >= TURN) deg -= TURN;
    r.node_angle = deg[ANGLE_OUT_BITS-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Random state vectors
  // --------------------------------------------------------------------------
  function automatic logic signed [FIELD_W-1:0] field_value(val_class_t cls);
    case (cls)
      VAL_SMALL: return FIELD_W'(int'($urandom_range(0, 8)) - 4);
      VAL_MID:   return FIELD_W'(int'($urandom_range(0, 65534)) - 32767);
      VAL_EXTREME: begin
        case ($urandom_range(0, 5))
          0:       return V_MIN;
          1:       return V_MAX;
          2:       return '1;
          3:       return '0;
          4:       return FIELD_W'(1);
          default: return $urandom;
        endcase
      end
      default:   return $urandom;
    endcase
  endfunction

  // Mostly full-range vectors, plus the shapes that reach the special
  // corners: exact axis and diagonal angles from tiny values, equatorial
  // orbits, parallel position and velocity, a node on a coordinate axis,
  // and mixes of extreme values.
  function automatic state_vec_t rand_state_vec();
    state_vec_t v;
    int         kind, k;
    val_class_t cls;
    kind = $urandom_range(0, 99);
    if (kind >= 45 && kind < 63)      cls = VAL_SMALL;
    else if (kind >= 73 && kind < 81) cls = VAL_MID;
    else if (kind >= 89)              cls = VAL_EXTREME;
    else                              cls = VAL_FULL;
    v.pos_x = field_value(cls);
    v.pos_y = field_value(cls);
    v.pos_z = field_value(cls);
    v.vel_x = field_value(cls);
    v.vel_y = field_value(cls);
    v.vel_z = field_value(cls);
    if (kind >= 63 && kind < 73) begin
      // Both vectors in the equatorial plane: h has no x or y part.
      v.pos_z = '0;
      v.vel_z = '0;
    end else if (kind >= 73 && kind < 81) begin
      k = int'($urandom_range(0, 6)) - 3;
      v.vel_x = FIELD_W'(k * int'(v.pos_x));
      v.vel_y = FIELD_W'(k * int'(v.pos_y));
      v.vel_z = FIELD_W'(k * int'(v.pos_z));
    end else if (kind >= 81 && kind < 89) begin
      if ($urandom_range(0, 1)) begin
        v.pos_x = '0;
        v.pos_z = '0;
      end else begin
        v.pos_y = '0;
        v.pos_z = '0;
      end
    end
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus side
  // --------------------------------------------------------------------------
  stim_item_t   state_vec_q [$];
  node_result_t node_angle_q [$];
  stim_item_t   cur_item;
  stim_item_t   dir_tab [20];
  int           sent_cnt;
  int           got_cnt;
  int           mismatch_cnt;
  int           hold_left;
  int           ang_err;
  node_result_t want_res;

  // The sender presents a new vector whenever the previous one has been
  // taken. Once valid is high it stays high until the transaction happens;
  // idle cycles are only inserted between transactions.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        node_angle_q.push_back(cur_item.has_want ? cur_item.want
                                                 : predict_node_angle(cur_item.vec));
        sent_cnt++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (state_vec_q.size() != 0 &&
            ((sent_cnt >= 200 && sent_cnt < 330) || $urandom_range(0, 99) >= IDLE_PCT)) begin
          cur_item = state_vec_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.pos_x <= cur_item.vec.pos_x;
          in_ch.pos_y <= cur_item.vec.pos_y;
          in_ch.pos_z <= cur_item.vec.pos_z;
          in_ch.vel_x <= cur_item.vec.vel_x;
          in_ch.vel_y <= cur_item.vec.vel_y;
          in_ch.vel_z <= cur_item.vec.vel_z;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------
  // Each result transaction is matched with the oldest expectation. The
  // receiver stalls at random, runs a stretch without stalls, and twice
  // holds ready low through a countdown from HOLD_LEN, so that the pipeline
  // fills up and backs up into the input channel.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (node_angle_q.size() == 0) begin
          $error("result transaction with nothing expected: node_angle %0d undefined %0b",
                 out_ch.node_angle, out_ch.undefined);
          mismatch_cnt++;
        end else begin
          want_res = node_angle_q.pop_front();
          if (out_ch.undefined !== want_res.undefined) begin
            $error("undefined: expected %0b, actual %0b",
                   want_res.undefined, out_ch.undefined);
            mismatch_cnt++;
          end
          // Angle distance taken around the circle, so that 359.99 and 0
          // count as neighbors.
          ang_err = (int'(out_ch.node_angle) - int'(want_res.node_angle) + TURN) % TURN;
          if ($isunknown(out_ch.node_angle) || out_ch.node_angle >= TURN ||
              (ang_err > ANG_TOL && ang_err < TURN - ANG_TOL)) begin
            $error("node_angle: expected %0d, actual %0d",
                   want_res.node_angle, out_ch.node_angle);
            mismatch_cnt++;
          end
        end
        got_cnt++;
        if (got_cnt == 60 || got_cnt == 420) hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (got_cnt >= 200 && got_cnt < 330) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Waits at falling edges until every vector is sent and every result is in.
  task automatic wait_drained();
    while (state_vec_q.size() != 0 || in_ch.valid || node_angle_q.size() != 0)
      @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Run sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.pos_x  = '0;
    in_ch.pos_y  = '0;
    in_ch.pos_z  = '0;
    in_ch.vel_x  = '0;
    in_ch.vel_y  = '0;
    in_ch.vel_z  = '0;
    out_ch.ready = 1'b0;
    sent_cnt     = 0;
    got_cnt      = 0;
    mismatch_cnt = 0;

    for (int i = 0; i < N_ROT; i++)
      rot_angle[i] = q60_to_q36(atan_q60(i));
    pi_q36 = q60_to_q36(4 * atan_q60(0));

    // Directed table: {pos_x, pos_y, pos_z, vel_x, vel_y, vel_z}, then
    // whether the result is given here, then {node_angle, undefined}.
    // A zero vector and the all-min and all-max vectors give h = 0.
    dir_tab[0]  = '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1, '{ANG_0, 1'b1}};
    dir_tab[1]  = '{'{V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN}, 1'b1, '{ANG_0, 1'b1}};
    dir_tab[2]  = '{'{V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX}, 1'b1, '{ANG_0, 1'b1}};
    // Node on each axis and each diagonal.
    dir_tab[3]  = '{'{32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd1}, 1'b1, '{ANG_0, 1'b0}};
    dir_tab[4]  = '{'{32'sd0, 32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd1}, 1'b1, '{ANG_90, 1'b0}};
    dir_tab[5]  = '{'{32'sd0, 32'sd0, 32'sd1, 32'sd1, 32'sd0, 32'sd0}, 1'b1, '{ANG_180, 1'b0}};
    dir_tab[6]  = '{'{32'sd0, 32'sd1, 32'sd0, 32'sd0, 32'sd0, -32'sd1}, 1'b1, '{ANG_270, 1'b0}};
    dir_tab[7]  = '{'{32'sd1, 32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd1}, 1'b1, '{ANG_45, 1'b0}};
    dir_tab[8]  = '{'{-32'sd1, 32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd1}, 1'b1, '{ANG_135, 1'b0}};
    dir_tab[9]  = '{'{-32'sd1, -32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd1}, 1'b1, '{ANG_225, 1'b0}};
    dir_tab[10] = '{'{32'sd1, -32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd1}, 1'b1, '{ANG_315, 1'b0}};
    // Node just below the x axis: rounds up to a full turn, which wraps.
    dir_tab[11] = '{'{V_MIN, 32'sd1, 32'sd0, 32'sd0, 32'sd0, -32'sd1}, 1'b1, '{ANG_0, 1'b0}};
    // Equatorial orbit with nonzero vectors, and parallel r and v.
    dir_tab[12] = '{'{32'sd7, -32'sd3, 32'sd0, 32'sd2, 32'sd5, 32'sd0}, 1'b1, '{ANG_0, 1'b1}};
    dir_tab[13] = '{'{32'sd3, -32'sd5, 32'sd9, -32'sd6, 32'sd10, -32'sd18}, 1'b1, '{ANG_0, 1'b1}};
    // Extreme mixes, including the largest |h_x|; these go to the model.
    dir_tab[14] = '{'{V_MIN, V_MIN, V_MAX, V_MAX, V_MIN, V_MIN}, 1'b0, '0};
    dir_tab[15] = '{'{32'sd0, V_MIN, V_MIN, V_MAX, 32'sd0, V_MIN}, 1'b0, '0};
    dir_tab[16] = '{'{V_MAX, V_MAX, V_MIN, V_MIN, V_MAX, V_MAX}, 1'b0, '0};
    dir_tab[17] = '{'{32'sd0, V_MIN, V_MIN, 32'sd0, V_MAX, V_MIN}, 1'b0, '0};
    dir_tab[18] = '{'{32'sd12345, -32'sd67890, 32'sd4242, -32'sd999, 32'sd31337, 32'sd27182},
                    1'b0, '0};
    dir_tab[19] = '{'{V_ALT, V_INV, V_ALT, V_INV, V_ALT, V_INV}, 1'b0, '0};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[i])
      state_vec_q.push_back(dir_tab[i]);
    wait_drained();

    repeat (N_RANDOM)
      state_vec_q.push_back(stim_item_t'{rand_state_vec(), 1'b0, '0});
    wait_drained();

    // Leave room for any stray result that follows the last expected one.
    repeat (DRAIN) @(negedge clk);
    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #200000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
